[rtl/core/dpd_pkg.sv]
// types, character codes and hex decode shared by the packet deframer
package dpd_pkg;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_DIGIT1  = 2'd2,
    PH_DIGIT2  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD  = 3'd0,
    EV_ACCEPT   = 3'd1,
    EV_MISMATCH = 3'd2,
    EV_ABORT    = 3'd3,
    EV_RESTART  = 3'd4
  } event_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] payload_byte;
    logic       reply_valid;
    logic [7:0] reply_char;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // low nibble of 'a'/'A' is 1, so add 9 to land on 10
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

[rtl/core/dpd_if.sv]
// valid/ready channel interfaces of the packet deframer

interface dpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dpd_cfg_if;
  logic valid;
  logic ready;
  logic ack_enabled;
  modport source (output valid, output ack_enabled, input ready);
  modport sink (input valid, input ack_enabled, output ready);
endinterface

interface dpd_res_if;
  logic                valid;
  logic                ready;
  dpd_pkg::event_t     event_res;
  logic [7:0]          payload_byte;
  logic                reply_valid;
  logic [7:0]          reply_char;
  modport source (output valid, output event_res, output payload_byte,
                  output reply_valid, output reply_char, input ready);
  modport sink (input valid, input event_res, input payload_byte,
                input reply_valid, input reply_char, output ready);
endinterface

[rtl/core/dpd_in_reg.sv]
// input register holding one received byte until the step logic takes it
module dpd_in_reg (
  input  logic        clk,
  input  logic        rst,
  dpd_rx_if.sink      rx,
  input  logic        advance,
  output logic        q_valid,
  output logic [7:0]  q_byte
);

  assign rx.ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (rx.ready) begin
      q_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      q_byte <= rx.rx_byte;
    end
  end

endmodule

[rtl/core/dpd_step.sv]
// framing state machine, checksum sum and per-byte result decode
module dpd_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          ack_enabled,
  input  logic          advance,
  input  logic [7:0]    rx_byte,
  output logic          has_result,
  output dpd_pkg::res_t res
);
  import dpd_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  logic       digit_bad;
  logic       digit_bad_next;
  hex_t       hex;
  logic       sum_match;

  assign hex       = hex_decode(rx_byte);
  assign sum_match = ({high_nibble, hex.val} == running_sum);

  // next state
  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    high_nibble_next = high_nibble;
    digit_bad_next   = digit_bad;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == CH_START) begin
          phase_next       = PH_COLLECT;
          running_sum_next = 8'd0;
        end
      end
      PH_COLLECT: begin
        if (rx_byte == CH_END) begin
          phase_next = PH_DIGIT1;
        end else if (rx_byte == CH_START) begin
          running_sum_next = 8'd0;
        end else begin
          running_sum_next = running_sum + rx_byte;
        end
      end
      PH_DIGIT1: begin
        high_nibble_next = hex.val;
        digit_bad_next   = !hex.ok;
        phase_next       = PH_DIGIT2;
      end
      PH_DIGIT2: begin
        digit_bad_next = 1'b0;
        if (!hex.ok || digit_bad || !ack_enabled || sum_match) begin
          phase_next = PH_HUNT;
        end else begin
          // mismatch: go straight back to collecting the retry
          phase_next       = PH_COLLECT;
          running_sum_next = 8'd0;
        end
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // outputs
  always_comb begin
    has_result       = 1'b0;
    res.event_res    = EV_PAYLOAD;
    res.payload_byte = 8'd0;
    res.reply_valid  = 1'b0;
    res.reply_char   = 8'd0;
    unique case (phase)
      PH_HUNT: begin
        has_result = 1'b0;
      end
      PH_COLLECT: begin
        if (rx_byte == CH_START) begin
          has_result    = 1'b1;
          res.event_res = EV_RESTART;
        end else if (rx_byte != CH_END) begin
          has_result       = 1'b1;
          res.payload_byte = rx_byte;
        end
      end
      PH_DIGIT1: begin
        has_result = 1'b0;
      end
      PH_DIGIT2: begin
        has_result = 1'b1;
        priority if (!hex.ok || digit_bad) begin
          res.event_res = EV_ABORT;
        end else if (!ack_enabled) begin
          res.event_res = EV_ACCEPT;
        end else if (sum_match) begin
          res.event_res   = EV_ACCEPT;
          res.reply_valid = 1'b1;
          res.reply_char  = CH_PLUS;
        end else begin
          res.event_res   = EV_MISMATCH;
          res.reply_valid = 1'b1;
          res.reply_char  = CH_MINUS;
        end
      end
      default: has_result = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      running_sum <= 8'd0;
      high_nibble <= 4'd0;
      digit_bad   <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      high_nibble <= high_nibble_next;
      digit_bad   <= digit_bad_next;
    end
  end

endmodule

[rtl/core/dpd_out_reg.sv]
// result register driving the outgoing channel
module dpd_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  dpd_pkg::res_t res_in,
  output logic          free,
  dpd_res_if.source     res
);
  import dpd_pkg::*;

  res_t data;

  // free when empty or the held request leaves this cycle
  assign free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (free) begin
      res.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      data <= res_in;
    end
  end

  assign res.event_res    = data.event_res;
  assign res.payload_byte = data.payload_byte;
  assign res.reply_valid  = data.reply_valid;
  assign res.reply_char   = data.reply_char;

endmodule

[rtl/core/debug_packet_deframer.sv]
// packet deframer top level: byte in, framing event and acknowledgement out
//
//   channel | dir | payload                                        | request
//   rx      | in  | rx_byte                                        | one received character
//   cfg     | in  | ack_enabled                                    | register write
//   res     | out | event_res, payload_byte, reply_valid, reply_char | one framing event
//
// one byte per cycle sustained unless a stall on res holds it; each byte is held in the input
// register and its result in the result register.
// rst (synchronous) clears the framing state to hunting and sets ack_enabled.
// a stall on res holds back only bytes that produce a result; others drain.
module debug_packet_deframer (
  input  logic      clk,
  input  logic      rst,
  dpd_rx_if.sink    rx,
  dpd_cfg_if.sink   cfg,
  dpd_res_if.source res
);
  import dpd_pkg::*;

  logic       q_valid;
  logic [7:0] q_byte;
  logic       advance;
  logic       has_result;
  logic       out_free;
  logic       ack_enabled;
  res_t       step_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_enabled <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      ack_enabled <= cfg.ack_enabled;
    end
  end

  assign advance = q_valid && (!has_result || out_free);

  dpd_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .advance (advance),
    .q_valid (q_valid),
    .q_byte  (q_byte)
  );

  dpd_step u_step (
    .clk         (clk),
    .rst         (rst),
    .ack_enabled (ack_enabled),
    .advance     (advance),
    .rx_byte     (q_byte),
    .has_result  (has_result),
    .res         (step_res)
  );

  dpd_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && has_result),
    .res_in (step_res),
    .free   (out_free),
    .res    (res)
  );

endmodule
